// File: rtl/uecc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uecc_pkg;

    // Field widths of the stream payload.
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned TYPE_W   = 3;
    localparam int unsigned DIGIT_W  = 4;

    // Default longest text that is still classified.
    localparam int unsigned MAX_TEXT_LEN_DEF = 20;

    // Code lengths of the supported symbologies.
    localparam int unsigned LEN_EAN13 = 13;
    localparam int unsigned LEN_UPCA  = 12;
    localparam int unsigned LEN_EAN8  = 8;

    // ASCII codes of interest.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

    // Code types, shared by the request and the detected result.
    typedef enum logic [TYPE_W-1:0] {
        TYPE_UNKNOWN = 3'd0,
        TYPE_EAN13   = 3'd1,
        TYPE_EAN8    = 3'd2,
        TYPE_UPCA    = 3'd3,
        TYPE_UPCE    = 3'd4
    } code_type_t;

    // Running text summary handed from the accumulator to the classifier.
    typedef struct packed {
        logic               all_digits;
        logic               first_01;
        logic [DIGIT_W-1:0] even_sum;
        logic [DIGIT_W-1:0] odd_sum;
        logic [DIGIT_W-1:0] check_digit;
    } text_summary_t;

    // Reduces a value below 40 modulo 10 with a few compares.
    function automatic logic [DIGIT_W-1:0] mod10_small(input logic [5:0] value);
        logic [5:0] r;
        begin
            if (value >= 6'd30) begin
                r = value - 6'd30;
            end else if (value >= 6'd20) begin
                r = value - 6'd20;
            end else if (value >= 6'd10) begin
                r = value - 6'd10;
            end else begin
                r = value;
            end
            return r[DIGIT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/uecc_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module uecc_accum #(
    parameter int unsigned MAX_TEXT_LEN = uecc_pkg::MAX_TEXT_LEN_DEF,
    parameter int unsigned CNT_W        = $clog2(MAX_TEXT_LEN + 2)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic [uecc_pkg::CHAR_W-1:0]   char_code,
    input  wire logic                          last_char,
    output logic      [CNT_W-1:0]              text_len,
    output uecc_pkg::text_summary_t            summary
);
    import uecc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_TEXT_LEN + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [DIGIT_W-1:0] even_sum_reg;
    logic [DIGIT_W-1:0] even_sum_next;
    logic [DIGIT_W-1:0] odd_sum_reg;
    logic [DIGIT_W-1:0] odd_sum_next;
    logic               first_01_reg;
    logic               first_01_next;
    logic               all_digits_reg;
    logic               all_digits_next;

    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               first_01_now;
    logic               all_digits_now;
    logic [CNT_W-1:0]   count_inc;

    // Decode the character of the current item.
    always_comb begin
        is_digit = (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE);
        digit    = is_digit ? DIGIT_W'(char_code - ASCII_ZERO) : '0;
        first_01_now = (count_reg == '0)
                     ? ((char_code == ASCII_ZERO) || (char_code == ASCII_ONE))
                     : first_01_reg;
        all_digits_now = all_digits_reg && is_digit;
        count_inc = (count_reg < CNT_SAT) ? (count_reg + CNT_W'(1)) : count_reg;
    end

    // Summary of the text including the current item, used on the last one.
    always_comb begin
        text_len            = count_inc;
        summary.all_digits  = all_digits_now;
        summary.first_01    = first_01_now;
        summary.even_sum    = even_sum_reg;
        summary.odd_sum     = odd_sum_reg;
        summary.check_digit = digit;
    end

    // Next running state: the last item returns the state to its reset values.
    always_comb begin
        count_next      = count_reg;
        even_sum_next   = even_sum_reg;
        odd_sum_next    = odd_sum_reg;
        first_01_next   = first_01_reg;
        all_digits_next = all_digits_reg;
        if (advance) begin
            if (last_char) begin
                count_next      = '0;
                even_sum_next   = '0;
                odd_sum_next    = '0;
                first_01_next   = 1'b0;
                all_digits_next = 1'b1;
            end else begin
                count_next      = count_inc;
                first_01_next   = first_01_now;
                all_digits_next = all_digits_now;
                if (count_reg[0] == 1'b0) begin
                    even_sum_next = mod10_small(6'(even_sum_reg) + 6'(digit));
                end else begin
                    odd_sum_next = mod10_small(6'(odd_sum_reg) + 6'(digit));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            even_sum_reg   <= '0;
            odd_sum_reg    <= '0;
            first_01_reg   <= 1'b0;
            all_digits_reg <= 1'b1;
        end else begin
            count_reg      <= count_next;
            even_sum_reg   <= even_sum_next;
            odd_sum_reg    <= odd_sum_next;
            first_01_reg   <= first_01_next;
            all_digits_reg <= all_digits_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/uecc_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module uecc_classify #(
    parameter int unsigned MAX_TEXT_LEN = uecc_pkg::MAX_TEXT_LEN_DEF,
    parameter int unsigned CNT_W        = $clog2(MAX_TEXT_LEN + 2)
) (
    input  wire logic [CNT_W-1:0]              text_len,
    input  uecc_pkg::text_summary_t            summary,
    input  wire logic [uecc_pkg::TYPE_W-1:0]   requested_type,
    input  wire logic                          pad_zeros,
    output uecc_pkg::code_type_t               detected_type,
    output logic                               is_valid
);
    import uecc_pkg::*;

    localparam logic [CNT_W-1:0] L13  = CNT_W'(LEN_EAN13);
    localparam logic [CNT_W-1:0] L12  = CNT_W'(LEN_UPCA);
    localparam logic [CNT_W-1:0] L8   = CNT_W'(LEN_EAN8);
    localparam logic [CNT_W-1:0] LMAX = CNT_W'(MAX_TEXT_LEN);

    logic               req_any;
    logic [CNT_W-1:0]   type_len;
    logic               type_known;
    logic [CNT_W-1:0]   eff_len;
    logic               eff_first_01;
    code_type_t         shape_type;
    logic [DIGIT_W-1:0] heavy;
    logic [DIGIT_W-1:0] light;
    logic [5:0]         weighted;
    logic [DIGIT_W-1:0] rem;
    logic               check_ok;

    // Length that belongs to the requested type.
    always_comb begin
        req_any = (requested_type == TYPE_UNKNOWN);
        case (requested_type)
            TYPE_EAN13:          type_len = L13;
            TYPE_UPCA:           type_len = L12;
            TYPE_EAN8, TYPE_UPCE: type_len = L8;
            default:             type_len = '0;
        endcase
        type_known = (type_len != '0);
    end

    // Optional leading-zero padding; padding makes the first digit a zero.
    always_comb begin
        eff_len      = text_len;
        eff_first_01 = summary.first_01;
        if (req_any) begin
            if (pad_zeros && (text_len != L13) && (text_len != L12) && (text_len != L8)
                    && (text_len <= LMAX)) begin
                if (text_len < L8) begin
                    eff_len      = L8;
                    eff_first_01 = 1'b1;
                end else if (text_len < L13) begin
                    eff_len      = L13;
                    eff_first_01 = 1'b1;
                end
            end
        end else if (pad_zeros && type_known && (text_len < type_len)) begin
            eff_len      = type_len;
            eff_first_01 = 1'b1;
        end
    end

    // Type by length and first digit.
    always_comb begin
        if (!summary.all_digits) begin
            shape_type = TYPE_UNKNOWN;
        end else if (eff_len == L13) begin
            shape_type = TYPE_EAN13;
        end else if (eff_len == L12) begin
            shape_type = TYPE_UPCA;
        end else if (eff_len == L8) begin
            shape_type = eff_first_01 ? TYPE_UPCE : TYPE_EAN8;
        end else begin
            shape_type = TYPE_UNKNOWN;
        end
    end

    // Mod-10 check digit; weight 3 falls on the index parity of the length.
    always_comb begin
        heavy    = eff_len[0] ? summary.odd_sum : summary.even_sum;
        light    = eff_len[0] ? summary.even_sum : summary.odd_sum;
        weighted = {1'b0, heavy, 1'b0} + 6'(heavy) + 6'(light);
        rem      = mod10_small(weighted);
        if (rem == '0) begin
            check_ok = (summary.check_digit == '0);
        end else begin
            check_ok = (summary.check_digit == (DIGIT_W'(10) - rem));
        end
    end

    // Detected type and match against the request.
    always_comb begin
        detected_type = check_ok ? shape_type : TYPE_UNKNOWN;
        if (req_any) begin
            is_valid = (detected_type != TYPE_UNKNOWN);
        end else begin
            is_valid = type_known
                    && ((detected_type == code_type_t'(requested_type))
                        || ((requested_type == TYPE_EAN8) && (detected_type == TYPE_UPCE)));
        end
    end

endmodule

`default_nettype wire

// File: rtl/upc_ean_code_checker_unit.sv
// EAN-13 / UPC-A / EAN-8 / UPC-E check-digit checker.
// The input stream carries the barcode text, one ASCII character per item:
// s_axis_tdata holds the character, s_axis_tlast marks the final character,
// and s_axis_tuser carries the requested type and the padding flag, which
// are only looked at together with the final character.
// Every final character produces exactly one result item on the output
// stream: m_axis_tdata holds the detected type and m_axis_tuser the match
// flag. Other characters produce no result.
// An item is registered at the input, processed by short combinational
// logic and the result is registered at the output.
// One item is accepted every cycle unless a final character waits for a
// full result register; the rate is set by the update of the running
// digit sums and the result register.
// When the receiver stalls, the result holds in the output register and
// characters keep flowing in; only a second final character waits until
// the output register is free, and the characters behind it wait with it.
// Reset clears both registers' valid flags and returns the running count,
// digit sums and flags to the start of a new text.
`timescale 1ns / 1ps
`default_nettype none

module upc_ean_code_checker_unit #(
    parameter int unsigned MAX_TEXT_LEN = uecc_pkg::MAX_TEXT_LEN_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Character stream.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  wire logic       s_axis_tlast,   // last_char
    input  wire logic [3:0] s_axis_tuser,   // [2:0] requested_type, [3] pad_zeros
    // Result stream.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [2:0] detected_type, [7:3] zero
    output logic            m_axis_tuser    // [0] is_valid
);
    import uecc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_TEXT_LEN + 2);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic [TYPE_W-1:0] in_req_reg;
    logic              in_pad_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    code_type_t        out_type_reg;
    logic              out_match_reg;

    logic              out_free;
    logic              advance;
    logic              accept;
    logic [CNT_W-1:0]  text_len;
    text_summary_t     summary;
    code_type_t        det_type;
    logic              det_valid;

    // Handshake: the input stage moves on unless it holds a final character
    // and the result register is still occupied.
    always_comb begin
        out_free       = !out_valid_reg || m_axis_tready;
        advance        = in_valid_reg && (!in_last_reg || out_free);
        s_axis_tready  = !in_valid_reg || advance;
        accept         = s_axis_tvalid && s_axis_tready;
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = (advance && in_last_reg) ? 1'b1
                       : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_req_reg  <= s_axis_tuser[TYPE_W-1:0];
            in_pad_reg  <= s_axis_tuser[TYPE_W];
        end
    end

    uecc_accum #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .CNT_W        (CNT_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .text_len  (text_len),
        .summary   (summary)
    );

    uecc_classify #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .CNT_W        (CNT_W)
    ) u_classify (
        .text_len       (text_len),
        .summary        (summary),
        .requested_type (in_req_reg),
        .pad_zeros      (in_pad_reg),
        .detected_type  (det_type),
        .is_valid       (det_valid)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_type_reg  <= det_type;
            out_match_reg <= det_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8 - TYPE_W){1'b0}}, out_type_reg};
    assign m_axis_tuser  = out_match_reg;

endmodule

`default_nettype wire

// File: sim/upc_ean_code_checker_unit_tb.sv
`timescale 1ns / 1ps

module upc_ean_code_checker_unit_tb;
    import uecc_pkg::*;

    localparam int TEXT_LEN_MAX = MAX_TEXT_LEN_DEF;

    // Request codes outside the defined types.
    localparam logic [2:0] REQ_RSVD_LO = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;

    // One verdict on a finished text.
    typedef struct packed {
        logic [2:0] det;
        logic       ok;
    } verdict_t;

    // One row of the directed table; a typed verdict overrides the prediction.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [2:0] req;
        logic       pad;
        logic       typed;
        logic [2:0] t_det;
        logic       t_ok;
    } char_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tlast = 1'b0;
    logic [3:0] s_axis_tuser = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;

    // Predictor state for the text being scanned.
    logic [4:0] text_len = '0;
    logic [3:0] even_acc = '0;
    logic [3:0] odd_acc = '0;
    bit         first_lead01 = 1'b0;
    bit         digits_ok = 1'b1;

    verdict_t verdicts_due[$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       chars_sent = 0;

    always #4 aclk = ~aclk;

    upc_ean_code_checker_unit #(
        .MAX_TEXT_LEN(TEXT_LEN_MAX)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Nominal length of a requested type; zero for any or reserved codes.
    function automatic int code_len(input logic [2:0] req);
        case (req)
            TYPE_EAN13: return LEN_EAN13;
            TYPE_UPCA: return LEN_UPCA;
            TYPE_EAN8, TYPE_UPCE: return LEN_EAN8;
            default: return 0;
        endcase
    endfunction

    // Classifies a text of final length len and verifies its check digit.
    function automatic logic [2:0] grade_code(input int len, input bit lead01,
                                              input bit digits, input logic [3:0] chk);
        logic [2:0] kind;
        int heavy;
        int light;
        int s;
        if (!digits) return TYPE_UNKNOWN;
        if (len == LEN_EAN13) begin
            kind = TYPE_EAN13;
        end else if (len == LEN_UPCA) begin
            kind = TYPE_UPCA;
        end else if (len == LEN_EAN8) begin
            kind = lead01 ? TYPE_UPCE : TYPE_EAN8;
        end else begin
            return TYPE_UNKNOWN;
        end
        // Weight 3 sits on the index parity that matches the length parity.
        heavy = (len % 2 == 0) ? int'(even_acc) : int'(odd_acc);
        light = (len % 2 == 0) ? int'(odd_acc) : int'(even_acc);
        s = (3 * heavy + light) % 10;
        return ((10 - s) % 10 == int'(chk)) ? kind : TYPE_UNKNOWN;
    endfunction

    // Advances the predictor by one character; a final character yields a verdict.
    task automatic scan_char(input logic [7:0] ch, input bit last, input logic [2:0] req,
                             input bit pad, output bit has, output verdict_t v);
        bit         is_dig;
        logic [3:0] dv;
        int         len;
        int         need;
        bit         lead;
        is_dig = (ch >= ASCII_ZERO) && (ch <= ASCII_NINE);
        dv = is_dig ? 4'(ch - ASCII_ZERO) : 4'd0;
        if (text_len == 0) first_lead01 = (ch == ASCII_ZERO) || (ch == ASCII_ONE);
        if (!is_dig) digits_ok = 1'b0;
        has = 1'b0;
        v = '0;
        if (!last) begin
            if (text_len[0] == 1'b0) begin
                even_acc = 4'((int'(even_acc) + int'(dv)) % 10);
            end else begin
                odd_acc = 4'((int'(odd_acc) + int'(dv)) % 10);
            end
            if (text_len < TEXT_LEN_MAX + 1) text_len++;
        end else begin
            len = int'(text_len);
            if (len < TEXT_LEN_MAX + 1) len++;
            lead = first_lead01;
            if (req == TYPE_UNKNOWN) begin
                // Any type: short texts pad up to EAN-8, middle lengths to EAN-13.
                if (pad && len != LEN_EAN13 && len != LEN_UPCA && len != LEN_EAN8
                        && len <= TEXT_LEN_MAX) begin
                    if (len < LEN_EAN8) begin
                        len = LEN_EAN8;
                        lead = 1'b1;
                    end else if (len < LEN_EAN13) begin
                        len = LEN_EAN13;
                        lead = 1'b1;
                    end
                end
                v.det = grade_code(len, lead, digits_ok, dv);
                v.ok = (v.det != TYPE_UNKNOWN);
            end else begin
                need = code_len(req);
                if (pad && need != 0 && len < need) begin
                    len = need;
                    lead = 1'b1;
                end
                v.det = grade_code(len, lead, digits_ok, dv);
                // EAN-8 requests also accept UPC-E.
                v.ok = (need != 0)
                    && ((v.det == req) || (req == TYPE_EAN8 && v.det == TYPE_UPCE));
            end
            has = 1'b1;
            text_len = '0;
            even_acc = '0;
            odd_acc = '0;
            first_lead01 = 1'b0;
            digits_ok = 1'b1;
        end
    endtask

    // Offers one character, waits for it to be taken and records its verdict.
    task automatic feed_char(input logic [7:0] ch, input bit last, input logic [2:0] req,
                             input bit pad, input bit typed, input verdict_t typed_v);
        bit       has;
        verdict_t v;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= last;
        s_axis_tuser <= {pad, req};
        do @(posedge aclk); while (!s_axis_tready);
        scan_char(ch, last, req, pad, has, v);
        if (has) verdicts_due.push_back(typed ? typed_v : v);
        chars_sent++;
    endtask

    function automatic logic [7:0] any_char();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h2F;
        if (r == 1) return 8'h3A;
        if (r < 4) return 8'($urandom_range(0, 255));
        return 8'(ASCII_ZERO + $urandom_range(0, 9));
    endfunction

    // Sends one random text: mostly well-formed codes, some noise.
    task automatic send_text();
        logic [7:0] body[$];
        int         n;
        int         r;
        int         s;
        int         d;
        logic [2:0] req;
        bit         pad;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            r = $urandom_range(0, 9);
            if (r < 2) n = LEN_EAN8;
            else if (r < 4) n = LEN_UPCA;
            else if (r < 6) n = LEN_EAN13;
            else if (r < 9) n = $urandom_range(1, 12);
            else n = $urandom_range(9, 11);
            // Leading 0 or 1 half the time so that UPC-E shows up.
            if ($urandom_range(0, 1)) body.push_back(8'(ASCII_ZERO + $urandom_range(0, 1)));
            else body.push_back(8'(ASCII_ZERO + $urandom_range(0, 9)));
            for (int i = 1; i < n - 1; i++) body.push_back(8'(ASCII_ZERO + $urandom_range(0, 9)));
            // Check digit from the distance to the end, so padding keeps it valid.
            s = 0;
            for (int i = 0; i < n - 1; i++) begin
                d = int'(body[i] - ASCII_ZERO);
                s += ((n - 1 - i) % 2 == 1) ? 3 * d : d;
            end
            if (n > 1 || body.size() == 0) begin
                if ($urandom_range(0, 99) < 80) body.push_back(8'(ASCII_ZERO + (10 - s % 10) % 10));
                else body.push_back(8'(ASCII_ZERO + $urandom_range(0, 9)));
            end
            req = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
        end else begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) body.push_back(any_char());
            req = 3'($urandom_range(0, 7));
        end
        pad = 1'($urandom_range(0, 1));
        for (int i = 0; i < body.size(); i++) begin
            if (i == body.size() - 1) begin
                feed_char(body[i], 1'b1, req, pad, 1'b0, '0);
            end else begin
                feed_char(body[i], 1'b0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'b0, '0);
            end
        end
    endtask

    // Result side: random stalls and the check against the oldest verdict.
    always @(posedge aclk) begin : result_check
        verdict_t v;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                flag_mismatch("unexpected result item", int'(m_axis_tdata), -1);
            end else begin
                v = verdicts_due.pop_front();
                if (m_axis_tdata[2:0] !== v.det) begin
                    flag_mismatch("detected_type", int'(m_axis_tdata[2:0]), int'(v.det));
                end
                if (m_axis_tuser !== v.ok) begin
                    flag_mismatch("is_valid", int'(m_axis_tuser), int'(v.ok));
                end
                if (m_axis_tdata[7:3] !== 5'd0) begin
                    flag_mismatch("tdata fill bits", int'(m_axis_tdata[7:3]), 0);
                end
            end
        end
    end

    // Directed texts, walked row by row.
    char_row_t dir_rows [23] = '{
        // Single digit without padding is too short.
        '{"0", 1'b1, TYPE_UNKNOWN, 1'b0, 1'b1, TYPE_UNKNOWN, 1'b0},
        // Non-digit at the top of the range with a reserved request.
        '{8'hFF, 1'b1, REQ_RSVD_HI, 1'b1, 1'b1, TYPE_UNKNOWN, 1'b0},
        // Non-digit early in the text poisons the whole text.
        '{8'h00, 1'b0, TYPE_EAN13, 1'b1, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"5", 1'b1, REQ_RSVD_LO, 1'b0, 1'b1, TYPE_UNKNOWN, 1'b0},
        // A valid EAN-8 code.
        '{"9", 1'b0, TYPE_UPCE, 1'b1, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"6", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"3", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"8", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"5", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"7", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"4", 1'b1, TYPE_EAN8, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        // A lone zero padded up to UPC-E.
        '{"0", 1'b1, TYPE_UPCE, 1'b1, 1'b0, TYPE_UNKNOWN, 1'b0},
        // Nine zeros padded up to EAN-13 on an any-type request.
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b0, TYPE_UNKNOWN, 1'b0, 1'b0, TYPE_UNKNOWN, 1'b0},
        '{"0", 1'b1, TYPE_UNKNOWN, 1'b1, 1'b0, TYPE_UNKNOWN, 1'b0},
        // Padded to UPC-A, but the check digit is wrong.
        '{"9", 1'b1, TYPE_UPCA, 1'b1, 1'b0, TYPE_UNKNOWN, 1'b0}
    };

    // Main sequence: reset, directed table, then four random phases.
    initial begin : stimulus
        verdict_t tv;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            tv.det = dir_rows[i].t_det;
            tv.ok = dir_rows[i].t_ok;
            feed_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].req, dir_rows[i].pad,
                      dir_rows[i].typed, tv);
        end

        for (int ph = 0; ph < 4; ph++) begin
            // Hold the sender until every verdict so far has come back.
            s_axis_tvalid <= 1'b0;
            while (verdicts_due.size() != 0) @(posedge aclk);
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 49;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 49;
                end
                default: begin
                    send_idle_pct = 20;
                    stall_pct = 20;
                end
            endcase
            while (chars_sent < 23 + 225 * (ph + 1)) send_text();
        end

        s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 5000 && verdicts_due.size() != 0; w++) @(posedge aclk);
        if (verdicts_due.size() != 0) begin
            flag_mismatch("results never delivered", 0, verdicts_due.size());
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[upc_ean_code_checker_unit] OK");
        end else begin
            $display("[upc_ean_code_checker_unit] ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin : watchdog
        #2000000;
        $display("[upc_ean_code_checker_unit] ERROR");
        $finish;
    end

endmodule
